### design/fqd_pkg.sv
// ----------------------------------------------------------------------------
// fqd_pkg
// Sizes, operation codes and state codes of the queue with delete by value.
// ----------------------------------------------------------------------------
package fqd_pkg;

	localparam int DEPTH       = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);

	localparam int OP_W    = 2;
	localparam int IN_W    = 32;
	localparam int OUT_W   = 32;
	localparam int LEN_W   = 5;

	localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
	localparam logic [OP_W-1:0] OP_DEL = 2'd2;
	localparam logic [OP_W-1:0] OP_LEN = 2'd3;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] S_IDLE   = 3'd0;
	localparam logic [ST_W-1:0] S_DECODE = 3'd1;
	localparam logic [ST_W-1:0] S_DEQ    = 3'd2;
	localparam logic [ST_W-1:0] S_SCAN   = 3'd3;
	localparam logic [ST_W-1:0] S_SHIFT  = 3'd4;

	typedef logic [VALUE_WIDTH-1:0] entry_t;
	typedef logic [ADDR_W-1:0]      addr_t;
	typedef logic [CNT_W-1:0]       count_t;

endpackage

### design/fifo_queue_with_delete_by_value.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_by_value
// Bounded first-in first-out queue of handles with enqueue, dequeue, delete by
// value and length operations, run by a small sequencer over one memory.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low, and busy stays high
// until its single result beat appears on status, value_out and length with
// done high for one cycle; the receiver cannot stall that beat. Length and
// enqueue answer from the decode state, dequeue from its read state. Delete
// compares one held entry per cycle from the head through the memory read port,
// then closes the gap one entry per cycle.
// No clearing pass is needed after reset.
module fifo_queue_with_delete_by_value
	import fqd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [OP_W-1:0]  op,
	input  logic [IN_W-1:0]  value,
	output logic             done,
	output logic             status,
	output logic [OUT_W-1:0] value_out,
	output logic [LEN_W-1:0] length
);

	function automatic addr_t slot_of(input addr_t h, input count_t off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(h) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(DEPTH)) begin
			sum = sum - (CNT_W+1)'(DEPTH);
		end
		return ADDR_W'(sum);
	endfunction

	logic [ST_W-1:0] state_q, state_d;
	logic [OP_W-1:0] op_q;
	entry_t          val_q;
	addr_t           head_q, head_d;
	count_t          count_q, count_d;
	addr_t           idx_q, idx_d;
	logic            done_q, done_d;
	logic            status_q, status_d;
	logic [OUT_W-1:0] vout_q, vout_d;

	logic   ram_we;
	addr_t  ram_waddr, ram_raddr;
	entry_t ram_wdata, ram_rdata;
	count_t idx_ext;

	assign idx_ext = CNT_W'(idx_q);

	fqd_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		idx_d     = idx_q;
		done_d    = 1'b0;
		status_d  = status_q;
		vout_d    = vout_q;
		ram_we    = 1'b0;
		ram_waddr = slot_of(head_q, idx_ext);
		ram_wdata = ram_rdata;
		ram_raddr = slot_of(head_q, idx_ext + CNT_W'(1));
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				done_d   = 1'b1;
				status_d = STATUS_OK;
				vout_d   = '0;
				state_d  = S_IDLE;
				case (op_q)
					OP_ENQ: begin
						if (val_q == '0 || count_q == CNT_W'(DEPTH)) begin
							status_d = STATUS_ERR;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = slot_of(head_q, count_q);
							ram_wdata = val_q;
							count_d   = count_q + CNT_W'(1);
						end
					end
					OP_DEQ: begin
						if (count_q == '0) begin
							status_d = STATUS_ERR;
						end else begin
							done_d    = 1'b0;
							ram_raddr = head_q;
							state_d   = S_DEQ;
						end
					end
					OP_DEL: begin
						if (val_q == '0 || count_q == '0) begin
							status_d = STATUS_ERR;
						end else begin
							done_d    = 1'b0;
							idx_d     = '0;
							ram_raddr = head_q;
							state_d   = S_SCAN;
						end
					end
					default: begin
					end
				endcase
			end
			S_DEQ: begin
				done_d   = 1'b1;
				status_d = STATUS_OK;
				vout_d   = OUT_W'(ram_rdata);
				head_d   = slot_of(head_q, CNT_W'(1));
				count_d  = count_q - CNT_W'(1);
				state_d  = S_IDLE;
			end
			S_SCAN: begin
				if (ram_rdata == val_q) begin
					if (idx_ext + CNT_W'(1) == count_q) begin
						done_d   = 1'b1;
						status_d = STATUS_OK;
						vout_d   = '0;
						count_d  = count_q - CNT_W'(1);
						state_d  = S_IDLE;
					end else begin
						state_d = S_SHIFT;
					end
				end else if (idx_ext + CNT_W'(1) == count_q) begin
					done_d   = 1'b1;
					status_d = STATUS_ERR;
					vout_d   = '0;
					state_d  = S_IDLE;
				end else begin
					idx_d = ADDR_W'(idx_ext + CNT_W'(1));
				end
			end
			S_SHIFT: begin
				ram_we = 1'b1;
				if (idx_ext + CNT_W'(2) == count_q) begin
					done_d   = 1'b1;
					status_d = STATUS_OK;
					vout_d   = '0;
					count_d  = count_q - CNT_W'(1);
					state_d  = S_IDLE;
				end else begin
					ram_raddr = slot_of(head_q, idx_ext + CNT_W'(2));
					idx_d     = ADDR_W'(idx_ext + CNT_W'(1));
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q  <= op;
			val_q <= VALUE_WIDTH'(value);
		end
		status_q <= status_d;
		vout_q   <= vout_d;
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign value_out = vout_q;
	assign length    = LEN_W'(count_q);

	// The count never exceeds the number of slots.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// A result beat is only given once the sequencer has returned to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result beat while sequencer busy");

	// An accepted operation makes the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted operation did not raise busy");

	// The head only moves on a dequeue, which removes exactly one entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		head_q != $past(head_q) |-> count_q + CNT_W'(1) == $past(count_q))
		else $error("head moved without removing one entry");

endmodule

### design/fqd_ram.sv
// ----------------------------------------------------------------------------
// fqd_ram
// Generic memory with one write port and one read port; the read is registered.
// ----------------------------------------------------------------------------
module fqd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
